/* sv/assert_macros.svh */
// assertion macros used by the console writer cell engine
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst, prop, msg)

`define ASSERT_NEVER(lbl, clk, rst, expr, msg)

`endif

`endif

/* sv/tmcw_pkg.sv */
// shared types and constants of the text mode console writer
`timescale 1ns / 1ps

package tmcw_pkg;

   localparam int COLUMNS_DEFAULT = 80;
   localparam int ROWS_DEFAULT    = 25;
   localparam int TAB_STOP        = 8;
   localparam int QUEUE_DEPTH     = 2;

   localparam logic [7:0] BLANK_CHAR = 8'h20;
   localparam logic [7:0] RESET_ATTR = 8'h0A;

   localparam logic [7:0] CHAR_BS = 8'd8;
   localparam logic [7:0] CHAR_HT = 8'd9;
   localparam logic [7:0] CHAR_LF = 8'd10;
   localparam logic [7:0] CHAR_CR = 8'd13;

   localparam logic [1:0] CMD_PUT   = 2'd0;
   localparam logic [1:0] CMD_CLEAR = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   localparam logic ADDR_TEXT_ATTRIBUTE = 1'b0;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_GLYPH,
      OP_NEWLINE,
      OP_RETURN,
      OP_TAB,
      OP_BACK,
      OP_CLEAR,
      OP_READ
   } op_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [7:0]  char_code;
      logic [10:0] cell_index;
   } req_type;

   typedef struct packed {
      logic [10:0] cursor_position;
      logic [15:0] cell_word;
      logic        scrolled;
   } rsp_type;

   typedef struct packed {
      op_type      op;
      logic [7:0]  char_code;
      logic [10:0] cell_index;
      logic        in_range;
   } entry_type;

endpackage

/* sv/text_mode_console_writer.sv */
// Text mode console writer: takes character, clear and read requests and keeps a
// ROWS x COLUMNS store of 16-bit cells (attribute high byte, character low byte).
// The cell memory has a single write port, which a clear or a scroll sweep walks
// one cell per cycle. Up to two requests queue ahead of the cell engine. After
// reset a clearing pass fills every cell with 0x0A20 and holds req_stall high;
// text_attribute writes are taken throughout.
`timescale 1ns / 1ps

module text_mode_console_writer #(
   parameter int COLUMNS = tmcw_pkg::COLUMNS_DEFAULT,
   parameter int ROWS    = tmcw_pkg::ROWS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  tmcw_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output tmcw_pkg::rsp_type  rsp_data,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   logic [7:0]          attr_ff, attr_in;
   logic                csr_hit;
   logic                q_push;
   logic                q_full;
   logic                q_pop;
   logic                q_empty;
   logic                init_busy;
   tmcw_pkg::entry_type q_entry;
   tmcw_pkg::entry_type q_head;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == tmcw_pkg::ADDR_TEXT_ATTRIBUTE);
   assign csr_prdata = csr_hit ? {24'b0, attr_ff} : '0;

   always_comb begin
      attr_in = attr_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         attr_in = csr_pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= tmcw_pkg::RESET_ATTR;
      end else begin
         attr_ff <= attr_in;
      end
   end

   tmcw_front #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_front (
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .q_full    (q_full),
      .init_busy (init_busy),
      .q_push    (q_push),
      .q_entry   (q_entry)
   );

   tmcw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .empty      (q_empty),
      .head       (q_head)
   );

   tmcw_back #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .attr      (attr_ff),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .init_busy (init_busy),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

/* sv/tmcw_front.sv */
// front end: accepts requests and classifies them into console operations
`timescale 1ns / 1ps

module tmcw_front #(
   parameter int COLUMNS = tmcw_pkg::COLUMNS_DEFAULT,
   parameter int ROWS    = tmcw_pkg::ROWS_DEFAULT
) (
   input  logic                 req_valid,
   input  tmcw_pkg::req_type    req_data,
   output logic                 req_stall,
   input  logic                 q_full,
   input  logic                 init_busy,
   output logic                 q_push,
   output tmcw_pkg::entry_type  q_entry
);

   localparam int CELLS = COLUMNS * ROWS;

   assign req_stall = q_full || init_busy;
   assign q_push    = req_valid && !req_stall;

   always_comb begin
      q_entry.char_code  = req_data.char_code;
      q_entry.cell_index = req_data.cell_index;
      q_entry.in_range   = (32'(req_data.cell_index) < CELLS);
      case (req_data.cmd)
         tmcw_pkg::CMD_PUT: begin
            case (req_data.char_code)
               tmcw_pkg::CHAR_LF: q_entry.op = tmcw_pkg::OP_NEWLINE;
               tmcw_pkg::CHAR_CR: q_entry.op = tmcw_pkg::OP_RETURN;
               tmcw_pkg::CHAR_HT: q_entry.op = tmcw_pkg::OP_TAB;
               tmcw_pkg::CHAR_BS: q_entry.op = tmcw_pkg::OP_BACK;
               default:           q_entry.op = tmcw_pkg::OP_GLYPH;
            endcase
         end
         tmcw_pkg::CMD_CLEAR: q_entry.op = tmcw_pkg::OP_CLEAR;
         tmcw_pkg::CMD_READ:  q_entry.op = tmcw_pkg::OP_READ;
         default:             q_entry.op = tmcw_pkg::OP_NONE;
      endcase
   end

endmodule

/* sv/tmcw_queue.sv */
// short request queue between the front end and the cell engine
`timescale 1ns / 1ps

module tmcw_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  tmcw_pkg::entry_type  push_entry,
   output logic                 full,
   input  logic                 pop,
   output logic                 empty,
   output tmcw_pkg::entry_type  head
);

   localparam int DEPTH = tmcw_pkg::QUEUE_DEPTH;
   localparam int QW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   tmcw_pkg::entry_type slots_ff [DEPTH];
   logic [QW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QW:0]   count_ff, count_in;

   assign full  = (count_ff == (QW+1)'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* sv/tmcw_back.sv */
// cell engine: cursor state, cell memory, scroll and clear sweeps, result register
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tmcw_back #(
   parameter int COLUMNS = tmcw_pkg::COLUMNS_DEFAULT,
   parameter int ROWS    = tmcw_pkg::ROWS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [7:0]           attr,
   input  logic                 q_empty,
   input  tmcw_pkg::entry_type  q_head,
   output logic                 q_pop,
   output logic                 init_busy,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output tmcw_pkg::rsp_type    rsp_data
);

   localparam int CELLS    = COLUMNS * ROWS;
   localparam int AW       = $clog2(CELLS);
   localparam int CB       = $clog2(COLUMNS);
   localparam int RB       = $clog2(ROWS);
   localparam int COPY_END = CELLS - COLUMNS;

   typedef enum logic [1:0] {
      S_SWEEP,
      S_IDLE,
      S_RDWAIT,
      S_DONE
   } state_type;

   state_type         state_ff, state_in;
   logic              init_ff, init_in;
   logic [RB-1:0]     row_ff, row_in;
   logic [CB-1:0]     col_ff, col_in;
   logic [AW-1:0]     base_ff, base_in;
   logic [AW-1:0]     ptr_ff, ptr_in;
   logic              copy_ff, copy_in;
   logic [15:0]       fill_ff, fill_in;
   logic              wr_valid_ff, wr_valid_in;
   logic              wr_mem_ff, wr_mem_in;
   logic [AW-1:0]     wr_addr_ff, wr_addr_in;
   logic [15:0]       wr_data_ff, wr_data_in;
   logic [15:0]       res_word_ff, res_word_in;
   logic              res_scrolled_ff, res_scrolled_in;
   logic              rd_range_ff, rd_range_in;
   logic              rsp_valid_ff, rsp_valid_in;
   tmcw_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [15:0]       cells_mem [CELLS];
   logic [15:0]       rd_data_ff;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;

   assign init_busy = init_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      logic          newline;
      logic          from_mem;
      logic          rsp_free;
      logic [CB:0]   tab_col;
      logic [CB:0]   col_inc;
      logic [AW-1:0] cur_addr;

      state_in        = state_ff;
      init_in         = init_ff;
      row_in          = row_ff;
      col_in          = col_ff;
      base_in         = base_ff;
      ptr_in          = ptr_ff;
      copy_in         = copy_ff;
      fill_in         = fill_ff;
      wr_valid_in     = 1'b0;
      wr_mem_in       = 1'b0;
      wr_addr_in      = wr_addr_ff;
      wr_data_in      = wr_data_ff;
      res_word_in     = res_word_ff;
      res_scrolled_in = res_scrolled_ff;
      rd_range_in     = rd_range_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_data_in     = rsp_data_ff;
      rd_en           = 1'b0;
      rd_addr         = '0;
      q_pop           = 1'b0;
      newline         = 1'b0;
      from_mem        = 1'b0;
      rsp_free        = !rsp_valid_ff || !rsp_stall;
      tab_col         = ((CB+1)'(col_ff) + (CB+1)'(tmcw_pkg::TAB_STOP))
                        & ~(CB+1)'(tmcw_pkg::TAB_STOP - 1);
      col_inc         = (CB+1)'(col_ff) + 1'b1;
      cur_addr        = base_ff + AW'(col_ff);

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_SWEEP: begin
            // copy phase reads one row ahead, the write takes the registered read data
            from_mem    = copy_ff && (ptr_ff < AW'(COPY_END));
            rd_en       = from_mem;
            rd_addr     = AW'({1'b0, ptr_ff} + (AW+1)'(COLUMNS));
            wr_valid_in = 1'b1;
            wr_mem_in   = from_mem;
            wr_addr_in  = ptr_ff;
            wr_data_in  = fill_ff;
            if (ptr_ff == AW'(CELLS - 1)) begin
               init_in  = 1'b0;
               state_in = init_ff ? S_IDLE : S_DONE;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (!q_empty) begin
               q_pop           = 1'b1;
               res_word_in     = '0;
               res_scrolled_in = 1'b0;
               state_in        = S_DONE;
               case (q_head.op)
                  tmcw_pkg::OP_NEWLINE: begin
                     col_in  = '0;
                     newline = 1'b1;
                  end
                  tmcw_pkg::OP_RETURN: begin
                     col_in = '0;
                  end
                  tmcw_pkg::OP_TAB: begin
                     if (tab_col >= (CB+1)'(COLUMNS)) begin
                        col_in  = '0;
                        newline = 1'b1;
                     end else begin
                        col_in = CB'(tab_col);
                     end
                  end
                  tmcw_pkg::OP_BACK: begin
                     if (col_ff != '0) begin
                        col_in      = col_ff - 1'b1;
                        wr_valid_in = 1'b1;
                        wr_addr_in  = cur_addr - 1'b1;
                        wr_data_in  = {attr, tmcw_pkg::BLANK_CHAR};
                     end
                  end
                  tmcw_pkg::OP_GLYPH: begin
                     wr_valid_in = 1'b1;
                     wr_addr_in  = cur_addr;
                     wr_data_in  = {attr, q_head.char_code};
                     if (col_inc >= (CB+1)'(COLUMNS)) begin
                        col_in  = '0;
                        newline = 1'b1;
                     end else begin
                        col_in = CB'(col_inc);
                     end
                  end
                  tmcw_pkg::OP_CLEAR: begin
                     row_in   = '0;
                     col_in   = '0;
                     base_in  = '0;
                     ptr_in   = '0;
                     copy_in  = 1'b0;
                     fill_in  = {attr, tmcw_pkg::BLANK_CHAR};
                     state_in = S_SWEEP;
                  end
                  tmcw_pkg::OP_READ: begin
                     rd_en       = q_head.in_range;
                     rd_addr     = AW'(q_head.cell_index);
                     rd_range_in = q_head.in_range;
                     state_in    = S_RDWAIT;
                  end
                  default: begin
                  end
               endcase
               if (newline) begin
                  if (row_ff == RB'(ROWS - 1)) begin
                     // cursor stays on the bottom row, the screen moves up
                     res_scrolled_in = 1'b1;
                     ptr_in          = '0;
                     copy_in         = 1'b1;
                     fill_in         = {attr, tmcw_pkg::BLANK_CHAR};
                     state_in        = S_SWEEP;
                  end else begin
                     row_in  = row_ff + 1'b1;
                     base_in = base_ff + AW'(COLUMNS);
                  end
               end
            end
         end
         S_RDWAIT: begin
            res_word_in = rd_range_ff ? rd_data_ff : '0;
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.cursor_position = 11'(cur_addr);
               rsp_data_in.cell_word       = res_word_ff;
               rsp_data_in.scrolled        = res_scrolled_ff;
               state_in                    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_SWEEP;
         init_ff         <= 1'b1;
         row_ff          <= '0;
         col_ff          <= '0;
         base_ff         <= '0;
         ptr_ff          <= '0;
         copy_ff         <= 1'b0;
         fill_ff         <= {tmcw_pkg::RESET_ATTR, tmcw_pkg::BLANK_CHAR};
         wr_valid_ff     <= 1'b0;
         wr_mem_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         init_ff         <= init_in;
         row_ff          <= row_in;
         col_ff          <= col_in;
         base_ff         <= base_in;
         ptr_ff          <= ptr_in;
         copy_ff         <= copy_in;
         fill_ff         <= fill_in;
         wr_valid_ff     <= wr_valid_in;
         wr_mem_ff       <= wr_mem_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      wr_addr_ff      <= wr_addr_in;
      wr_data_ff      <= wr_data_in;
      res_word_ff     <= res_word_in;
      res_scrolled_ff <= res_scrolled_in;
      rd_range_ff     <= rd_range_in;
      rsp_data_ff     <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (wr_valid_ff) begin
         cells_mem[wr_addr_ff] <= wr_mem_ff ? rd_data_ff : wr_data_ff;
      end
      if (rd_en) begin
         rd_data_ff <= cells_mem[rd_addr];
      end
   end

   `ASSERT_PROP(a_cursor_in_bounds, clock, reset, (32'(col_ff) < COLUMNS) && (32'(row_ff) < ROWS), "cursor outside the screen")
   `ASSERT_PROP(a_base_tracks_row, clock, reset, 32'(base_ff) == 32'(row_ff) * COLUMNS, "row base out of step with cursor row")
   `ASSERT_PROP(a_copy_after_read, clock, reset, (wr_valid_ff && wr_mem_ff) |-> $past(rd_en), "scroll copy without a read behind it")
   `ASSERT_NEVER(a_write_in_range, clock, reset, wr_valid_ff && (32'(wr_addr_ff) >= CELLS), "cell write beyond the screen")

endmodule

/* verif/tb.sv */
// self-checking testbench of the text mode console writer
`timescale 1ns / 1ps

module tb;

   localparam int COLS = tmcw_pkg::COLUMNS_DEFAULT;
   localparam int ROWS_N = tmcw_pkg::ROWS_DEFAULT;
   localparam int CELLS = COLS * ROWS_N;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam logic [2:0] TEXT_ATTR_ADDR = 3'(4 * int'(tmcw_pkg::ADDR_TEXT_ATTRIBUTE));
   localparam int LIMIT_CYCLES = 3_000_000;
   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES = 2100;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   tmcw_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   tmcw_pkg::rsp_type rsp_data;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [2:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   text_mode_console_writer u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // mirror of the screen, cursor and attribute
   logic [15:0] screen_mem [CELLS];
   int unsigned cur_row;
   int unsigned cur_col;
   logic [7:0] text_attr;

   tmcw_pkg::rsp_type awaited_rsp [$];
   int mismatch_count = 0;
   int cycle_count = 0;
   bit idle_on = 1'b0;
   int hold_req = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int stall_left = 0;

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got 0x%0h expected 0x%0h at %0t", what, got, want, $realtime);
      mismatch_count++;
   endtask

   function automatic logic [15:0] blank_cell();
      return {text_attr, tmcw_pkg::BLANK_CHAR};
   endfunction

   function automatic void blank_screen();
      int i;
      for (i = 0; i < CELLS; i++) screen_mem[i] = blank_cell();
      cur_row = 0;
      cur_col = 0;
   endfunction

   function automatic int unsigned cursor_index();
      return cur_row * COLS + cur_col;
   endfunction

   // updates the mirror and returns the response this request should produce
   function automatic tmcw_pkg::rsp_type apply_console_request(input tmcw_pkg::req_type r);
      tmcw_pkg::rsp_type res;
      int i;
      res = '0;
      case (r.cmd)
         tmcw_pkg::CMD_PUT: begin
            case (r.char_code)
               tmcw_pkg::CHAR_LF: begin
                  cur_col = 0;
                  cur_row++;
               end
               tmcw_pkg::CHAR_CR: cur_col = 0;
               tmcw_pkg::CHAR_HT: begin
                  cur_col = (cur_col + tmcw_pkg::TAB_STOP) & ~(tmcw_pkg::TAB_STOP - 1);
                  if (cur_col >= COLS) begin
                     cur_col = 0;
                     cur_row++;
                  end
               end
               tmcw_pkg::CHAR_BS: begin
                  if (cur_col > 0) begin
                     cur_col--;
                     screen_mem[cursor_index()] = blank_cell();
                  end
               end
               default: begin
                  screen_mem[cursor_index()] = {text_attr, r.char_code};
                  cur_col++;
                  if (cur_col >= COLS) begin
                     cur_col = 0;
                     cur_row++;
                  end
               end
            endcase
            if (cur_row >= ROWS_N) begin
               for (i = 0; i < CELLS - COLS; i++) screen_mem[i] = screen_mem[i + COLS];
               for (i = CELLS - COLS; i < CELLS; i++) screen_mem[i] = blank_cell();
               cur_row--;
               res.scrolled = 1'b1;
            end
         end
         tmcw_pkg::CMD_CLEAR: blank_screen();
         tmcw_pkg::CMD_READ: begin
            if (r.cell_index < CELLS) res.cell_word = screen_mem[r.cell_index];
         end
         default: ;
      endcase
      res.cursor_position = 11'(cursor_index());
      return res;
   endfunction

   function automatic tmcw_pkg::req_type make_req(input logic [1:0] cmd, input logic [7:0] ch,
                                                  input logic [10:0] idx);
      tmcw_pkg::req_type r;
      r.cmd = cmd;
      r.char_code = ch;
      r.cell_index = idx;
      return r;
   endfunction

   function automatic int pick_gap();
      int roll;
      if (!idle_on) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // offers one request and returns at the edge where it is accepted
   task automatic send_request(input tmcw_pkg::req_type r);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      awaited_rsp.push_back(apply_console_request(r));
   endtask

   task automatic send_char(input logic [7:0] ch);
      send_request(make_req(tmcw_pkg::CMD_PUT, ch, 11'($urandom_range(0, 2047))));
   endtask

   task automatic send_read(input logic [10:0] idx);
      send_request(make_req(tmcw_pkg::CMD_READ, 8'($urandom_range(0, 255)), idx));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (awaited_rsp.size() != 0);
   endtask

   task automatic write_text_attribute(input logic [7:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= TEXT_ATTR_ADDR;
      csr_pwdata <= {24'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      text_attr = value;
   endtask

   task automatic change_attribute(input logic [7:0] value);
      wait_drained();
      repeat (4) @(posedge clock);
      write_text_attribute(value);
   endtask

   // response checker
   always @(posedge clock) begin
      tmcw_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_rsp.size() == 0) begin
            report_mismatch("unexpected response", rsp_data, 0);
         end else begin
            want = awaited_rsp.pop_front();
            if (rsp_data.cursor_position !== want.cursor_position)
               report_mismatch("cursor_position", rsp_data.cursor_position,
                               want.cursor_position);
            if (rsp_data.cell_word !== want.cell_word)
               report_mismatch("cell_word", rsp_data.cell_word, want.cell_word);
            if (rsp_data.scrolled !== want.scrolled)
               report_mismatch("scrolled", rsp_data.scrolled, want.scrolled);
         end
      end
   end

   // receiver stalls: random bursts, plus a long hold on request
   always @(posedge clock) begin
      if (hold_req != hold_seen) begin
         hold_seen = hold_req;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!idle_on) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 99) < 25) begin
         stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                                  : $urandom_range(0, 2);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic test_reset_state();
      send_read(11'd0);
      send_read(11'(CELLS - 1));
      send_read(11'd2047);
      send_request(make_req(CMD_UNUSED, 8'hFF, 11'h7FF));
   endtask

   task automatic test_control_chars();
      int i;
      idle_on = 1'b1;
      send_char(8'h00);
      send_char(8'hFF);
      send_char(8'h7F);
      send_char(tmcw_pkg::CHAR_BS);
      send_read(11'd2);
      send_char(tmcw_pkg::CHAR_CR);
      // backspace at column 0 must do nothing
      send_char(tmcw_pkg::CHAR_BS);
      send_char(tmcw_pkg::CHAR_LF);
      // the last tab runs past the final column and wraps
      for (i = 0; i < COLS / tmcw_pkg::TAB_STOP; i++) send_char(tmcw_pkg::CHAR_HT);
      send_request(make_req(tmcw_pkg::CMD_CLEAR, 8'h41, 11'd5));
      send_read(11'd0);
   endtask

   task automatic test_backpressure();
      int i;
      idle_on = 1'b0;
      hold_req++;
      for (i = 0; i < 12; i++) begin
         if (i % 3 == 2) send_read(11'(cursor_index()));
         else send_char(8'($urandom_range(32, 126)));
      end
      // sender stops until every response is back
      wait_drained();
   endtask

   task automatic random_text_phase(input int count);
      int sent;
      int roll;
      int run;
      int k;
      int unsigned pos;
      sent = 0;
      while (sent < count) begin
         if (sent % 40 == 0) idle_on = ($urandom_range(0, 3) != 0);
         roll = $urandom_range(0, 99);
         if (roll < 55) begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 90) : $urandom_range(1, 12);
            for (k = 0; k < run && sent < count; k++) begin
               send_char(8'($urandom_range(0, 255)));
               sent++;
            end
         end else begin
            if (roll < 70) send_char(tmcw_pkg::CHAR_LF);
            else if (roll < 76) send_char(tmcw_pkg::CHAR_CR);
            else if (roll < 82) send_char(tmcw_pkg::CHAR_HT);
            else if (roll < 88) send_char(tmcw_pkg::CHAR_BS);
            else if (roll < 92) begin
               pos = cursor_index();
               k = $urandom_range(1, 8);
               send_read(11'((pos >= k) ? pos - k : pos));
            end else if (roll < 96) send_read(11'($urandom_range(0, 2047)));
            else if (roll < 99) send_request(make_req(CMD_UNUSED, 8'($urandom_range(0, 255)),
                                                      11'($urandom_range(0, 2047))));
            else send_request(make_req(tmcw_pkg::CMD_CLEAR, 8'($urandom_range(0, 255)),
                                       11'($urandom_range(0, 2047))));
            sent++;
         end
      end
   endtask

   task automatic test_random_text();
      change_attribute(8'h00);
      random_text_phase(100);
      change_attribute(8'hFF);
      random_text_phase(100);
      change_attribute(8'($urandom_range(0, 255)));
      random_text_phase(100);
   endtask

   initial begin
      text_attr = tmcw_pkg::RESET_ATTR;
      blank_screen();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      // let the power-up clearing pass finish
      @(posedge clock);
      @(posedge clock);
      while (req_stall) @(posedge clock);

      test_reset_state();
      test_control_chars();
      test_backpressure();
      test_random_text();

      idle_on = 1'b0;
      wait_drained();
      repeat (50) @(posedge clock);
      if (mismatch_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule
